/* rtl/ring_segment_vertex_generator_defines.svh */
// Assertion macros shared by the ring segment vertex generator RTL.
`ifndef RING_SEGMENT_VERTEX_GENERATOR_DEFINES_SVH
`define RING_SEGMENT_VERTEX_GENERATOR_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RSVG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsvg check failed");

// Implication checked on every rising clock edge outside reset.
`define RSVG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsvg check failed");

`endif

/* rtl/rsvg_pkg.sv */
package rsvg_pkg;

  localparam int unsigned MAX_SEGMENTS     = 4096;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned U_W    = 17;
  localparam int unsigned PH_W   = 16;
  localparam int unsigned FRAC_W = 14;
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

  // quotient bits per division, retired three per cycle
  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIV_ITERS = 6;
  localparam int unsigned DIV_BITS  = DIV_STEPS * DIV_ITERS;
  localparam int unsigned DIV_CW    = 3;
  localparam int unsigned REM_W     = CNT_W + 1;
  localparam int unsigned DVD_W     = IDX_W + 1 + PH_W + 1;

  localparam int unsigned VTX_W       = 3;
  localparam logic [VTX_W-1:0] LAST_VERTEX = 3'd5;

  // register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  typedef logic [MAG_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // one table entry: Taylor series of sin up to x^15, unsigned Q1.16
  function automatic logic [MAG_W-1:0] series_sine(input int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(j) * 64'd1686629713) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    t  = ((t * x2) >> 30) / 6;   s = s - t;
    t  = ((t * x2) >> 30) / 20;  s = s + t;
    t  = ((t * x2) >> 30) / 42;  s = s - t;
    t  = ((t * x2) >> 30) / 72;  s = s + t;
    t  = ((t * x2) >> 30) / 110; s = s - t;
    t  = ((t * x2) >> 30) / 156; s = s + t;
    t  = ((t * x2) >> 30) / 210; s = s - t;
    r = (s + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[MAG_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int unsigned j = 0; j <= SINE_TABLE_DEPTH; j++) begin
      rom[j] = series_sine(j);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

/* rtl/ring_segment_vertex_generator.sv */
// Ring segment vertex generator. Each accepted segment index yields six vertices
// (outer cur, inner cur, outer next, inner cur, inner next, outer next), one per
// cycle while the output is not stalled. The two u fractions come from a shared
// radix-8 divider: the accepting edge loads it, each later step retires three
// quotient bits and the last three bits go straight into the expander, so a new
// index can be taken while the previous segment is still being emitted. The first
// vertex passes the divider, the expander and a 4-stage vertex pipeline (vertex
// fields, table address, registered sine ROM read, radius multiply), with signs
// and bad-index zeroing applied at the output. A stalled output item holds the
// expander and vertex pipeline and, once the divider waits on a finished index,
// the input. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must do so only while idle, as the block itself does not enforce it.
`include "ring_segment_vertex_generator_defines.svh"

module ring_segment_vertex_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rsvg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rsvg_pkg::RAD_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rsvg_pkg::IDX_W-1:0]       segment_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [rsvg_pkg::POS_W-1:0] pos_x_o,
  output logic signed [rsvg_pkg::POS_W-1:0] pos_y_o,
  output logic [rsvg_pkg::U_W-1:0]         tex_u_o,
  output logic                             tex_v_o,
  output logic                             bad_index_o,
  output logic                             last_o
);
  import rsvg_pkg::*;

  // configuration registers
  logic [RAD_W-1:0] outer_q, inner_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= RAD_W'(256);
      inner_q <= RAD_W'(128);
      count_q <= CNT_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OUTER: outer_q <= cfg_data_i;
        REG_INNER: inner_q <= cfg_data_i;
        REG_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_eff;
  assign n_eff = (count_q > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : count_q;

  // pipeline advance: the expander and vertex stages move unless the output item is stalled
  logic en;
  logic s4_vld_q;
  assign en = !s4_vld_q || out_ready_i;

  // ---------------- divider: u0 = idx<<16 / n, u1 = (idx+1)<<16 / n
  logic              div_vld_q, div_bad_q;
  logic [DIV_CW-1:0] div_cnt_q;
  logic [CNT_W-1:0]  div_n_q;
  logic [REM_W-1:0]  rem0_q, rem1_q, rem0_d, rem1_d;
  logic [DIV_BITS-1:0] sh0_q, sh1_q, quo0_q, quo1_q, quo0_d, quo1_d;
  logic              div_done, exp_free, div_xfer, in_acc;

  // last three quotient bits are taken on the transfer edge
  assign div_done   = div_vld_q && (div_cnt_q == DIV_CW'(DIV_ITERS - 1));
  assign in_ready_o = !div_vld_q || (div_done && exp_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign div_xfer   = div_done && exp_free;

  logic [DVD_W-1:0] dvd0, dvd1;
  assign dvd0 = {1'b0, 1'b0, segment_index_i, {PH_W{1'b0}}};
  assign dvd1 = {1'b0, (IDX_W + 1)'(segment_index_i) + (IDX_W + 1)'(1), {PH_W{1'b0}}};

  // three restoring steps per cycle for both quotients
  always_comb begin
    logic [REM_W-1:0] r0, r1;
    r0 = rem0_q;
    r1 = rem1_q;
    quo0_d = quo0_q;
    quo1_d = quo1_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r0 = {r0[REM_W-2:0], sh0_q[DIV_BITS-1-k]};
      r1 = {r1[REM_W-2:0], sh1_q[DIV_BITS-1-k]};
      quo0_d = {quo0_d[DIV_BITS-2:0], (r0 >= REM_W'(div_n_q))};
      quo1_d = {quo1_d[DIV_BITS-2:0], (r1 >= REM_W'(div_n_q))};
      if (r0 >= REM_W'(div_n_q)) r0 = r0 - REM_W'(div_n_q);
      if (r1 >= REM_W'(div_n_q)) r1 = r1 - REM_W'(div_n_q);
    end
    rem0_d = r0;
    rem1_d = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= 1'b0;
      div_cnt_q <= '0;
    end else if (in_acc) begin
      div_vld_q <= 1'b1;
      div_cnt_q <= '0;
    end else begin
      if (div_xfer) div_vld_q <= 1'b0;
      if (div_vld_q && !div_done) div_cnt_q <= div_cnt_q + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      div_n_q   <= n_eff;
      div_bad_q <= (n_eff == '0) || ({1'b0, segment_index_i} >= n_eff);
      rem0_q    <= REM_W'(dvd0[DVD_W-1:DIV_BITS]);
      rem1_q    <= REM_W'(dvd1[DVD_W-1:DIV_BITS]);
      sh0_q     <= dvd0[DIV_BITS-1:0];
      sh1_q     <= dvd1[DIV_BITS-1:0];
      quo0_q    <= '0;
      quo1_q    <= '0;
    end else if (div_vld_q && !div_done) begin
      rem0_q <= rem0_d;
      rem1_q <= rem1_d;
      sh0_q  <= sh0_q << DIV_STEPS;
      sh1_q  <= sh1_q << DIV_STEPS;
      quo0_q <= quo0_d;
      quo1_q <= quo1_d;
    end
  end

  // ---------------- expander: one vertex item per cycle while the output is not stalled
  logic             exp_vld_q, exp_bad_q;
  logic [VTX_W-1:0] exp_cnt_q;
  logic [U_W-1:0]   exp_u0_q, exp_u1_q;
  logic             exp_last;

  assign exp_last = exp_cnt_q == LAST_VERTEX;
  assign exp_free = !exp_vld_q || (en && exp_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_vld_q <= 1'b0;
      exp_cnt_q <= '0;
    end else if (div_xfer) begin
      exp_vld_q <= 1'b1;
      exp_cnt_q <= '0;
    end else if (exp_vld_q && en) begin
      if (exp_last) exp_vld_q <= 1'b0;
      exp_cnt_q <= exp_cnt_q + VTX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_xfer) begin
      exp_bad_q <= div_bad_q;
      exp_u0_q  <= quo0_d[U_W-1:0];
      exp_u1_q  <= quo1_d[U_W-1:0];
    end
  end

  // vertex pattern: v 0,1,0,1,1,0 and next-angle 0,0,1,0,1,1
  logic tok_v, tok_nxt;
  always_comb begin
    case (exp_cnt_q)
      3'd0:    begin tok_v = 1'b0; tok_nxt = 1'b0; end
      3'd1:    begin tok_v = 1'b1; tok_nxt = 1'b0; end
      3'd2:    begin tok_v = 1'b0; tok_nxt = 1'b1; end
      3'd3:    begin tok_v = 1'b1; tok_nxt = 1'b0; end
      3'd4:    begin tok_v = 1'b1; tok_nxt = 1'b1; end
      default: begin tok_v = 1'b0; tok_nxt = 1'b1; end
    endcase
  end

  // ---------------- stage 1: vertex fields
  logic             s1_vld_q, s1_v_q, s1_bad_q, s1_last_q;
  logic [U_W-1:0]   s1_u_q;
  logic [RAD_W-1:0] s1_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= exp_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v_q    <= tok_v;
      s1_bad_q  <= exp_bad_q;
      s1_last_q <= exp_last;
      s1_u_q    <= tok_nxt ? exp_u1_q : exp_u0_q;
      s1_rad_q  <= tok_v ? inner_q : outer_q;
    end
  end

  // ---------------- stage 2: table addresses and signs
  function automatic logic [ADDR_W-1:0] tab_addr(input logic [PH_W-1:0] p);
    logic [FRAC_W+ADDR_W-1:0] prod;
    logic [ADDR_W-1:0]        idx;
    prod = (FRAC_W + ADDR_W)'(p[FRAC_W-1:0]) * (FRAC_W + ADDR_W)'(SINE_TABLE_DEPTH);
    idx  = prod[FRAC_W +: ADDR_W];
    return p[FRAC_W] ? ADDR_W'(SINE_TABLE_DEPTH) - idx : idx;
  endfunction

  logic [PH_W-1:0] ph_s, ph_c;
  assign ph_s = s1_u_q[PH_W-1:0];
  assign ph_c = ph_s + PH_W'(16384);

  logic              s2_vld_q, s2_v_q, s2_bad_q, s2_last_q, s2_sneg_q, s2_cneg_q;
  logic [U_W-1:0]    s2_u_q;
  logic [RAD_W-1:0]  s2_rad_q;
  logic [ADDR_W-1:0] s2_sa_q, s2_ca_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (en) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_v_q    <= s1_v_q;
      s2_bad_q  <= s1_bad_q;
      s2_last_q <= s1_last_q;
      s2_u_q    <= s1_u_q;
      s2_rad_q  <= s1_rad_q;
      s2_sa_q   <= tab_addr(ph_s);
      s2_ca_q   <= tab_addr(ph_c);
      s2_sneg_q <= ph_s[PH_W-1];
      s2_cneg_q <= ph_c[PH_W-1];
    end
  end

  // ---------------- stage 3: registered sine ROM read
  logic             s3_vld_q, s3_v_q, s3_bad_q, s3_last_q, s3_sneg_q, s3_cneg_q;
  logic [U_W-1:0]   s3_u_q;
  logic [RAD_W-1:0] s3_rad_q;
  logic [MAG_W-1:0] s3_sm_q, s3_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (en) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_v_q    <= s2_v_q;
      s3_bad_q  <= s2_bad_q;
      s3_last_q <= s2_last_q;
      s3_u_q    <= s2_u_q;
      s3_rad_q  <= s2_rad_q;
      s3_sneg_q <= s2_sneg_q;
      s3_cneg_q <= s2_cneg_q;
      s3_sm_q   <= SINE_ROM[s2_sa_q];
      s3_cm_q   <= SINE_ROM[s2_ca_q];
    end
  end

  // ---------------- stage 4: radius scaling with rounding
  localparam int unsigned PROD_W = MAG_W + RAD_W;
  logic [PROD_W-1:0] sprod, cprod;
  assign sprod = PROD_W'(s3_sm_q) * PROD_W'(s3_rad_q) + PROD_W'(32768);
  assign cprod = PROD_W'(s3_cm_q) * PROD_W'(s3_rad_q) + PROD_W'(32768);

  logic             s4_v_q, s4_bad_q, s4_last_q, s4_sneg_q, s4_cneg_q;
  logic [U_W-1:0]   s4_u_q;
  logic [POS_W-1:0] s4_sm_q, s4_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (en) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_v_q    <= s3_v_q;
      s4_bad_q  <= s3_bad_q;
      s4_last_q <= s3_last_q;
      s4_u_q    <= s3_u_q;
      s4_sneg_q <= s3_sneg_q;
      s4_cneg_q <= s3_cneg_q;
      s4_sm_q   <= sprod[16 +: POS_W];
      s4_cm_q   <= cprod[16 +: POS_W];
    end
  end

  // ---------------- output: signs and bad-index zeroing
  assign out_valid_o = s4_vld_q;
  assign pos_x_o     = s4_bad_q ? '0 : (s4_sneg_q ? s4_sm_q : -s4_sm_q);
  assign pos_y_o     = s4_bad_q ? '0 : (s4_cneg_q ? -s4_cm_q : s4_cm_q);
  assign tex_u_o     = s4_bad_q ? '0 : s4_u_q;
  assign tex_v_o     = s4_v_q;
  assign bad_index_o = s4_bad_q;
  assign last_o      = s4_last_q;

  // ---------------- checks
  `RSVG_ASSERT(a_div_cnt_range, div_cnt_q <= DIV_CW'(DIV_ITERS))
  `RSVG_ASSERT_IMP(a_exp_cnt_range, exp_vld_q, exp_cnt_q <= LAST_VERTEX)
  `RSVG_ASSERT_IMP(a_accept_free, in_acc, !div_vld_q || div_xfer)
  `RSVG_ASSERT_IMP(a_bad_zero, out_valid_o && bad_index_o,
                   pos_x_o == '0 && pos_y_o == '0 && tex_u_o == '0)

endmodule

/* tb/testbench.sv */
module testbench;
  import rsvg_pkg::*;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [U_W-1:0]          tex_u;
    logic                    tex_v;
    logic                    bad_index;
    logic                    last;
  } vertex_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [RAD_W-1:0]          cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [IDX_W-1:0]          segment_index_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [POS_W-1:0]   pos_x_o;
  logic signed [POS_W-1:0]   pos_y_o;
  logic [U_W-1:0]            tex_u_o;
  logic                      tex_v_o;
  logic                      bad_index_o;
  logic                      last_o;

  ring_segment_vertex_generator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .segment_index_i,
    .out_valid_o, .out_ready_i, .pos_x_o, .pos_y_o, .tex_u_o,
    .tex_v_o, .bad_index_o, .last_o
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and the quarter-wave table
  logic [RAD_W-1:0] outer_r;
  logic [RAD_W-1:0] inner_r;
  logic [CNT_W-1:0] seg_count;
  logic [MAG_W-1:0] sine_lut [0:SINE_TABLE_DEPTH];

  vertex_t     vertex_queue[$];
  int unsigned errors;
  int unsigned quiet_cycles;
  bit          stall_long;

  function automatic logic [MAG_W-1:0] taylor_entry(int unsigned j);
    logic [63:0] x, x2, t, s, r;
    int unsigned d;
    x  = (64'(j) * 64'd1686629713) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    for (int unsigned k = 1; k <= 7; k++) begin
      d = (2 * k) * (2 * k + 1);
      t = ((t * x2) >> 30) / d;
      if (k % 2) s = s - t;
      else s = s + t;
    end
    r = (s + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[MAG_W-1:0];
  endfunction

  // signed sine of a 16-bit phase, as magnitude plus sign
  function automatic logic [MAG_W-1:0] wave_mag(logic [15:0] ph, output bit neg);
    logic [1:0]  quad;
    int unsigned slot;
    quad = ph[15:14];
    slot = (int'(ph[13:0]) * SINE_TABLE_DEPTH) >> 14;
    neg  = quad[1];
    return quad[0] ? sine_lut[SINE_TABLE_DEPTH - slot] : sine_lut[slot];
  endfunction

  function automatic logic [POS_W-1:0] scale(logic [MAG_W-1:0] mag, bit neg,
                                             logic [RAD_W-1:0] rad);
    logic [63:0] m;
    m = (64'(mag) * 64'(rad) + 64'd32768) >> 16;
    return neg ? POS_W'(-m) : POS_W'(m);
  endfunction

  function automatic vertex_t make_vertex(logic [U_W-1:0] u, logic [RAD_W-1:0] rad,
                                          bit v, bit bad, bit lst);
    vertex_t vx;
    bit sn, cn;
    logic [MAG_W-1:0] s, c;
    s = wave_mag(u[15:0], sn);
    c = wave_mag(u[15:0] + 16'd16384, cn);
    vx.pos_x     = bad ? '0 : scale(s, !sn, rad);
    vx.pos_y     = bad ? '0 : scale(c, cn, rad);
    vx.tex_u     = bad ? '0 : u;
    vx.tex_v     = v;
    vx.bad_index = bad;
    vx.last      = lst;
    return vx;
  endfunction

  // append one expected vertex item
  task automatic add_expected(vertex_t vx);
    vertex_queue.insert(vertex_queue.size(), vx);
  endtask

  task automatic predict_segment(logic [IDX_W-1:0] idx);
    int unsigned n;
    bit bad;
    logic [U_W-1:0] u0, u1;
    n   = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
    bad = (n == 0) || (idx >= n);
    u0  = '0;
    u1  = '0;
    if (!bad) begin
      u0 = U_W'((64'(idx) << 16) / n);
      u1 = U_W'(((64'(idx) + 64'd1) << 16) / n);
    end
    add_expected(make_vertex(u0, outer_r, 0, bad, 0));
    add_expected(make_vertex(u0, inner_r, 1, bad, 0));
    add_expected(make_vertex(u1, outer_r, 0, bad, 0));
    add_expected(make_vertex(u0, inner_r, 1, bad, 0));
    add_expected(make_vertex(u1, inner_r, 1, bad, 0));
    add_expected(make_vertex(u1, outer_r, 0, bad, 1));
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // send one segment index and wait for its acceptance; valid is dropped by
  // the next gap or drain, so back to back items keep it high
  task automatic send_segment(logic [IDX_W-1:0] idx, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    segment_index_i <= idx;
    predict_segment(idx);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_OUTER: outer_r = val;
      REG_INNER: inner_r = val;
      REG_COUNT: seg_count = val[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_ring(logic [RAD_W-1:0] o, logic [RAD_W-1:0] i, logic [CNT_W-1:0] n);
    wait_drained();
    write_reg(REG_OUTER, o);
    write_reg(REG_INNER, i);
    write_reg(REG_COUNT, RAD_W'(n));
  endtask

  // reset values, edge indexes, wrap of the last segment
  task automatic test_reset_defaults();
    send_segment(0, 0);
    send_segment(1, 0);
    send_segment(31, 0);
    send_segment(32, 0);
    send_segment(12'hFFF, 0);
  endtask

  // extreme radii, inner above outer, count of one
  task automatic test_extremes();
    set_ring(16'hFFFF, 16'hFFFF, 1);
    send_segment(0, 0);
    send_segment(1, 0);
    set_ring(16'h0000, 16'hFFFF, 4096);
    send_segment(0, 0);
    send_segment(4095, 0);
    send_segment(2048, 0);
    set_ring(16'hAAAA, 16'h5555, 3);
    send_segment(0, 0);
    send_segment(1, 0);
    send_segment(2, 0);
    send_segment(3, 0);
  endtask

  // zero count and counts above the maximum
  task automatic test_count_limits();
    set_ring(16'h1234, 16'h0800, 0);
    send_segment(0, 0);
    send_segment(12'h555, 0);
    set_ring(16'h8000, 16'h4000, 13'h1FFF);
    send_segment(4095, 0);
    send_segment(12'hAAA, 0);
    set_ring(16'h0100, 16'h0080, 4097);
    send_segment(4095, 0);
  endtask

  // output held off long enough to fill the block
  task automatic test_backpressure();
    set_ring(16'h0300, 16'h0200, 64);
    stall_long = 1'b1;
    for (int k = 0; k < 8; k++) send_segment(12'($urandom_range(0, 70)), 0);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      set_ring(16'($urandom), 16'($urandom), 13'($urandom_range(1, 300)));
      if (ph == 4) write_reg(REG_COUNT, 16'($urandom_range(0, 8191)));
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) < 8)
          send_segment(12'($urandom_range(0, seg_count > 0 ? seg_count - 1 : 0)),
                       ph != 2);
        else
          send_segment(12'($urandom), ph != 2);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_long) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        stall_long = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        out_ready_i <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      vertex_t exp_v;
      if (vertex_queue.size() == 0) begin
        $error("vertex with no expectation");
        errors++;
      end else begin
        exp_v = vertex_queue.pop_front();
        if (pos_x_o !== exp_v.pos_x) begin
          $error("pos_x: expected %0d, got %0d", exp_v.pos_x, pos_x_o); errors++;
        end
        if (pos_y_o !== exp_v.pos_y) begin
          $error("pos_y: expected %0d, got %0d", exp_v.pos_y, pos_y_o); errors++;
        end
        if (tex_u_o !== exp_v.tex_u) begin
          $error("tex_u: expected %0d, got %0d", exp_v.tex_u, tex_u_o); errors++;
        end
        if (tex_v_o !== exp_v.tex_v) begin
          $error("tex_v: expected %0d, got %0d", exp_v.tex_v, tex_v_o); errors++;
        end
        if (bad_index_o !== exp_v.bad_index) begin
          $error("bad_index: expected %0d, got %0d", exp_v.bad_index, bad_index_o);
          errors++;
        end
        if (last_o !== exp_v.last) begin
          $error("last: expected %0d, got %0d", exp_v.last, last_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors          = 0;
    quiet_cycles    = 0;
    stall_long      = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_OUTER;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    segment_index_i = '0;
    outer_r         = 16'd256;
    inner_r         = 16'd128;
    seg_count       = 13'd32;
    for (int unsigned j = 0; j <= SINE_TABLE_DEPTH; j++) sine_lut[j] = taylor_entry(j);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_count_limits();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* ring_segment_vertex_generator.f */
+incdir+rtl
rtl/rsvg_pkg.sv
rtl/ring_segment_vertex_generator.sv
tb/testbench.sv
